### design/utf8_lowercase_folder_core_assert.svh
// Assertion macros for the checker file.
`ifndef UTF8_LOWERCASE_FOLDER_CORE_ASSERT_SVH
`define UTF8_LOWERCASE_FOLDER_CORE_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define U8LF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("u8lf assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define U8LF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("u8lf assertion failed");

// Next-cycle implication that is also checked through reset.
`define U8LF_ASSERT_ALWAYS(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("u8lf assertion failed");

`endif

### design/u8lf_pkg.sv
// Types, constants and fold/encode functions for the UTF-8 lowercase folder.
package u8lf_pkg;

    localparam int PointW  = 21;
    localparam int LaneCnt = 5;
    localparam int IdxW    = $clog2(LaneCnt + 1);

    typedef logic [PointW-1:0] t_point;
    typedef logic [7:0]        t_byte;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } t_enc;

    function automatic t_point fold_point(t_point cp);
        t_point r;
        r = cp;
        if (cp >= 21'h41 && cp <= 21'h5A) begin
            r = cp + 21'h20;
        end else if (cp >= 21'h410 && cp <= 21'h42F) begin
            r = cp + 21'h20;
        end else if (cp == 21'h401) begin
            r = 21'h451;
        end
        return r;
    endfunction

    function automatic t_enc encode_point(t_point raw);
        t_point cp;
        t_enc   e;
        cp = fold_point(raw);
        e  = '0;
        if (cp < 21'h80) begin
            e.bytes[0] = cp[7:0];
            e.len      = 3'd1;
        end else if (cp < 21'h800) begin
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.len      = 3'd2;
        end else if (cp < 21'h10000) begin
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.len      = 3'd3;
        end else begin
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
            e.len      = 3'd4;
        end
        return e;
    endfunction

endpackage

### design/u8lf_intf.sv
// Valid/ready channel interfaces for the input bytes and the result bytes.
interface u8lf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       text_end;

    modport source (output valid, output in_byte, output text_end, input ready);
    modport sink   (input valid, input in_byte, input text_end, output ready);
endinterface

interface u8lf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_done;

    modport source (output valid, output out_byte, output run_last, output text_done,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input text_done,
                    output ready);
endinterface

### design/utf8_lowercase_folder_core.sv
// Path: an input item is encoded into the staging register, then sent out by the byte serializer.
// Throughput: one output byte per cycle while the output is ready; an input item yields
// 0..5 bytes, and the byte serializer takes the next item only after its last byte transfers.
// Input is ready while the staging register is empty or drains into the serializer.
// Synchronous active-low reset clears the decoder state and empties both stages.
module utf8_lowercase_folder_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    u8lf_in_if.sink   i_in,
    u8lf_out_if.source o_out
);
    import u8lf_pkg::*;

    // decoder state
    t_point     r_pp;
    logic [1:0] r_exp;
    t_point     n_pp;
    logic [1:0] n_exp;

    // staged item: encoded bytes of up to two code points
    logic                        r_a_valid;
    t_byte  [LaneCnt-1:0]        r_a_lanes;
    logic   [IdxW-1:0]           r_a_cnt;
    logic                        r_a_end;

    // byte serializer
    logic                        r_b_valid;
    t_byte  [LaneCnt-1:0]        r_b_lanes;
    logic   [IdxW-1:0]           r_b_cnt;
    logic   [IdxW-1:0]           r_b_idx;
    logic                        r_b_end;

    logic                 in_acc;
    logic                 out_acc;
    logic                 b_last;
    logic                 b_free;
    logic                 f_vld;
    logic                 l_vld;
    logic                 do_lead;
    t_point               f_pt;
    t_point               l_pt;
    t_point               pp2;
    t_enc                 enc_f;
    t_enc                 enc_l;
    logic [IdxW-1:0]      len_f;
    logic [IdxW-1:0]      len_l;
    logic [IdxW-1:0]      tot;
    logic [IdxW-1:0]      diff;
    t_byte [LaneCnt-1:0]  lanes;

    // staging register refills in the cycle it hands its item to the serializer
    assign i_in.ready = !r_a_valid || b_free;
    assign in_acc     = i_in.valid && (!r_a_valid || b_free);

    assign b_last  = (r_b_idx == r_b_cnt - 3'd1);
    assign out_acc = r_b_valid && o_out.ready;
    assign b_free  = !r_b_valid || (out_acc && b_last);

    assign o_out.valid     = r_b_valid;
    assign o_out.out_byte  = r_b_lanes[r_b_idx];
    assign o_out.run_last  = b_last;
    assign o_out.text_done = b_last && r_b_end;

    // Slot F: completed or broken-off sequence. Slot L: lead byte value or end flush.
    always_comb begin
        f_vld   = 1'b0;
        f_pt    = r_pp;
        l_vld   = 1'b0;
        l_pt    = {13'd0, i_in.in_byte};
        n_pp    = r_pp;
        n_exp   = r_exp;
        do_lead = 1'b0;
        pp2     = {r_pp[14:0], i_in.in_byte[5:0]};

        if (r_exp != 2'd0) begin
            if (i_in.in_byte[7:6] == 2'b10) begin
                n_exp = r_exp - 2'd1;
                if (n_exp == 2'd0) begin
                    f_vld = 1'b1;
                    f_pt  = pp2;
                    n_pp  = '0;
                end else begin
                    n_pp = pp2;
                end
            end else begin
                // broken sequence: flush, then treat this byte as a lead
                f_vld   = 1'b1;
                n_pp    = '0;
                n_exp   = 2'd0;
                do_lead = 1'b1;
            end
        end else begin
            do_lead = 1'b1;
        end

        if (do_lead) begin
            priority if (!i_in.in_byte[7]) begin
                l_vld = 1'b1;
            end else if (i_in.in_byte[7:5] == 3'b110) begin
                n_pp  = {16'd0, i_in.in_byte[4:0]};
                n_exp = 2'd1;
            end else if (i_in.in_byte[7:4] == 4'b1110) begin
                n_pp  = {17'd0, i_in.in_byte[3:0]};
                n_exp = 2'd2;
            end else if (i_in.in_byte[7:3] == 5'b11110) begin
                n_pp  = {18'd0, i_in.in_byte[2:0]};
                n_exp = 2'd3;
            end else begin
                l_vld = 1'b1;   // stray byte stands for itself
            end
        end

        if (i_in.text_end) begin
            if (n_exp != 2'd0) begin
                l_vld = 1'b1;
                l_pt  = n_pp;
            end
            n_pp  = '0;
            n_exp = 2'd0;
        end

        enc_f = encode_point(f_pt);
        enc_l = encode_point(l_pt);
        len_f = f_vld ? enc_f.len : 3'd0;
        len_l = l_vld ? enc_l.len : 3'd0;
        tot   = len_f + len_l;

        for (int k = 0; k < LaneCnt; k++) begin
            diff = 3'(k) - len_f;
            if (3'(k) < len_f) begin
                lanes[k] = enc_f.bytes[2'(k)];
            end else begin
                lanes[k] = enc_l.bytes[diff[1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pp      <= '0;
            r_exp     <= 2'd0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_b_idx   <= '0;
        end else begin
            if (in_acc) begin
                r_pp  <= n_pp;
                r_exp <= n_exp;
            end
            if (in_acc && tot != 3'd0) begin
                r_a_valid <= 1'b1;
            end else if (b_free) begin
                r_a_valid <= 1'b0;
            end
            if (b_free) begin
                r_b_valid <= r_a_valid;
                r_b_idx   <= '0;
            end else if (out_acc) begin
                r_b_idx <= r_b_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_lanes <= lanes;
            r_a_cnt   <= tot;
            r_a_end   <= i_in.text_end;
        end
        if (b_free) begin
            r_b_lanes <= r_a_lanes;
            r_b_cnt   <= r_a_cnt;
            r_b_end   <= r_a_end;
        end
    end

endmodule

### design/u8lf_checker.sv
// Port-level checker for the UTF-8 lowercase folder, bound to the folder core.
`include "utf8_lowercase_folder_core_assert.svh"

module u8lf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_run_last,
    input logic       i_text_done
);
    // a stalled result holds
    `U8LF_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_byte) && $stable(i_run_last) && $stable(i_text_done))
    // end of text is always the last byte of its item
    `U8LF_ASSERT_NOW(a_done_is_last, i_out_valid && i_text_done, i_run_last)
    // reset leaves the input side ready
    `U8LF_ASSERT_ALWAYS(a_reset_ready, !i_rst_n, i_in_ready)
    // reset empties the output side
    `U8LF_ASSERT_ALWAYS(a_reset_empty, !i_rst_n, !i_out_valid)
endmodule

bind utf8_lowercase_folder_core u8lf_checker u_u8lf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_run_last  (o_out.run_last),
    .i_text_done (o_out.text_done)
);

### tb/u8lf_fold_sb_pkg.sv
// Scoreboard class for the UTF-8 lowercase folder: predicts and checks output bytes.
package u8lf_fold_sb_pkg;
    import u8lf_pkg::*;

    typedef struct packed {
        t_byte out_byte;
        logic  run_last;
        logic  text_done;
    } t_fold_byte;

    class fold_scoreboard;
        t_point     partial_cp;
        logic [1:0] conts_left;
        t_fold_byte expected_q[$];
        t_fold_byte step_q[$];
        int         mismatches;

        function new();
            partial_cp = '0;
            conts_left = '0;
            mismatches = 0;
        endfunction

        function t_point lower_cp(t_point cp);
            if (cp >= 21'h41 && cp <= 21'h5A) begin
                return cp + 21'h20;
            end
            if (cp >= 21'h410 && cp <= 21'h42F) begin
                return cp + 21'h20;
            end
            if (cp == 21'h401) begin
                return 21'h451;
            end
            return cp;
        endfunction

        function void push_byte(t_byte b);
            t_fold_byte fb;
            fb.out_byte  = b;
            fb.run_last  = 1'b0;
            fb.text_done = 1'b0;
            step_q = {step_q, fb};
        endfunction

        function void encode_cp(t_point raw);
            t_point cp;
            cp = lower_cp(raw);
            if (cp < 21'h80) begin
                push_byte(cp[7:0]);
            end else if (cp < 21'h800) begin
                push_byte({3'b110, cp[10:6]});
                push_byte({2'b10, cp[5:0]});
            end else if (cp < 21'h10000) begin
                push_byte({4'b1110, cp[15:12]});
                push_byte({2'b10, cp[11:6]});
                push_byte({2'b10, cp[5:0]});
            end else begin
                push_byte({5'b11110, cp[20:18]});
                push_byte({2'b10, cp[17:12]});
                push_byte({2'b10, cp[11:6]});
                push_byte({2'b10, cp[5:0]});
            end
        endfunction

        function void start_lead(t_byte b);
            if (b < 8'h80) begin
                encode_cp({13'd0, b});
            end else if (b[7:5] == 3'b110) begin
                partial_cp = {16'd0, b[4:0]};
                conts_left = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                partial_cp = {17'd0, b[3:0]};
                conts_left = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                partial_cp = {18'd0, b[2:0]};
                conts_left = 2'd3;
            end else begin
                // stray continuation or 0xF8..0xFF: the byte value is the code point
                encode_cp({13'd0, b});
            end
        endfunction

        // Called on every accepted input transfer.
        function void note_input(t_byte b, logic last_in_text);
            t_fold_byte fb;
            int         idx;
            step_q.delete();
            if (conts_left != 2'd0) begin
                if (b[7:6] == 2'b10) begin
                    partial_cp = {partial_cp[14:0], b[5:0]};
                    conts_left = conts_left - 2'd1;
                    if (conts_left == 2'd0) begin
                        encode_cp(partial_cp);
                        partial_cp = '0;
                    end
                end else begin
                    // broken sequence: flush what was gathered, then restart on this byte
                    encode_cp(partial_cp);
                    partial_cp = '0;
                    conts_left = '0;
                    start_lead(b);
                end
            end else begin
                start_lead(b);
            end
            if (last_in_text) begin
                if (conts_left != 2'd0) begin
                    encode_cp(partial_cp);
                end
                partial_cp = '0;
                conts_left = '0;
            end
            if (step_q.size() > 0) begin
                idx          = step_q.size() - 1;
                fb           = step_q[idx];
                fb.run_last  = 1'b1;
                fb.text_done = last_in_text;
                step_q[idx]  = fb;
            end
            expected_q = {expected_q, step_q};
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        // Called on every accepted output transfer.
        task check_out(t_byte b, logic rl, logic td);
            t_fold_byte want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected output byte %02h", b));
                return;
            end
            want = expected_q.pop_front();
            if (b !== want.out_byte) begin
                report_mismatch($sformatf("out_byte %02h, want %02h", b, want.out_byte));
            end
            if (rl !== want.run_last) begin
                report_mismatch($sformatf("run_last %b, want %b (byte %02h)",
                                          rl, want.run_last, want.out_byte));
            end
            if (td !== want.text_done) begin
                report_mismatch($sformatf("text_done %b, want %b (byte %02h)",
                                          td, want.text_done, want.out_byte));
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

endpackage

### tb/tb_top.sv
// Top-level testbench: drives UTF-8 text into the folder and checks the lowercased bytes.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import u8lf_pkg::*;
    import u8lf_fold_sb_pkg::*;

    localparam int CycleLimit  = 400000;
    localparam int TextItems   = 420;
    localparam int CalmFirst   = 150;
    localparam int CalmLast    = 260;
    localparam int IdlePercent = 38;

    typedef struct packed {
        t_byte b;
        logic  last;
    } t_text_item;

    logic i_clk;
    logic i_rst_n;
    logic calm;
    int   cycle_count;

    t_text_item     text_q[$];
    fold_scoreboard sb;

    u8lf_in_if  in_ch();
    u8lf_out_if out_ch();

    utf8_lowercase_folder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task add_item(t_byte b, logic e);
        t_text_item it;
        it.b    = b;
        it.last = e;
        text_q = {text_q, it};
    endtask

    function t_byte rand_cont();
        return {2'b10, 6'($urandom_range(63))};
    endfunction

    // Mostly well-formed characters with random content, some truncated ones and noise.
    task add_random_char();
        int    kind;
        int    n_cont;
        t_byte lead;
        kind = $urandom_range(99);
        if (kind < 30) begin
            if ($urandom_range(1) == 0) begin
                lead = 8'($urandom_range(8'h5A, 8'h41));
            end else begin
                lead = 8'($urandom_range(8'h7F));
            end
            n_cont = 0;
        end else if (kind < 55) begin
            lead   = ($urandom_range(1) == 0) ? 8'hD0 : 8'hD1;
            n_cont = 1;
        end else if (kind < 65) begin
            lead   = 8'($urandom_range(8'hDF, 8'hC0));
            n_cont = 1;
        end else if (kind < 75) begin
            lead   = 8'($urandom_range(8'hEF, 8'hE0));
            n_cont = 2;
        end else if (kind < 82) begin
            lead   = 8'($urandom_range(8'hF7, 8'hF0));
            n_cont = 3;
        end else if (kind < 90) begin
            // cut short: the next character breaks it
            if ($urandom_range(1) == 0) begin
                lead   = 8'($urandom_range(8'hEF, 8'hE0));
                n_cont = $urandom_range(1);
            end else begin
                lead   = 8'($urandom_range(8'hF7, 8'hF0));
                n_cont = $urandom_range(2);
            end
        end else begin
            lead   = 8'($urandom_range(255));
            n_cont = 0;
        end
        add_item(lead, $urandom_range(99) < 4);
        for (int k = 0; k < n_cont; k++) begin
            add_item(rand_cont(), $urandom_range(99) < 4);
        end
    endtask

    task build_text();
        // ASCII fold edges and field extremes
        add_item(8'h41, 1'b0);
        add_item(8'h5A, 1'b0);
        add_item(8'h40, 1'b0);
        add_item(8'h5B, 1'b0);
        add_item(8'h00, 1'b0);
        add_item(8'h7F, 1'b1);
        // Cyrillic capital A, capital YA, capital IO
        add_item(8'hD0, 1'b0);
        add_item(8'h90, 1'b0);
        add_item(8'hD0, 1'b0);
        add_item(8'hAF, 1'b0);
        add_item(8'hD0, 1'b0);
        add_item(8'h81, 1'b0);
        // largest four-byte value
        add_item(8'hF7, 1'b0);
        add_item(8'hBF, 1'b0);
        add_item(8'hBF, 1'b0);
        add_item(8'hBF, 1'b0);
        // stray bytes
        add_item(8'h80, 1'b0);
        add_item(8'hFF, 1'b0);
        // broken three-byte sequence ended by a stray byte
        add_item(8'hE2, 1'b0);
        add_item(8'h82, 1'b0);
        add_item(8'hF8, 1'b0);
        // broken two-byte sequence ended by an uppercase letter
        add_item(8'hD0, 1'b0);
        add_item(8'h41, 1'b0);
        // broken four-byte sequence, new lead opened and flushed at end of text
        add_item(8'hF0, 1'b0);
        add_item(8'h9F, 1'b0);
        add_item(8'h98, 1'b0);
        add_item(8'hC3, 1'b1);
        while (text_q.size() < TextItems) begin
            add_random_char();
        end
    endtask

    task send_text();
        for (int i = 0; i < text_q.size(); i++) begin
            calm = (i >= CalmFirst && i < CalmLast);
            while (!calm && $urandom_range(99) < IdlePercent) begin
                in_ch.valid <= 1'b0;
                @(posedge i_clk);
            end
            in_ch.valid    <= 1'b1;
            in_ch.in_byte  <= text_q[i].b;
            in_ch.text_end <= text_q[i].last;
            @(posedge i_clk);
            while (in_ch.ready !== 1'b1) begin
                @(posedge i_clk);
            end
            sb.note_input(text_q[i].b, text_q[i].last);
        end
        calm = 1'b0;
        in_ch.valid <= 1'b0;
    endtask

    // output side: check each transfer, stall at random
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
                sb.check_out(out_ch.out_byte, out_ch.run_last, out_ch.text_done);
            end
            out_ch.ready <= calm || ($urandom_range(99) >= IdlePercent);
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[utf8_lowercase_folder_core] ERROR");
        $finish;
    end

    initial begin
        sb   = new();
        calm = 1'b0;
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.in_byte  <= '0;
        in_ch.text_end <= 1'b0;
        build_text();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_text();
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        // room for any stray bytes the block might still send
        repeat (16) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("[utf8_lowercase_folder_core] OK");
        end else begin
            $display("[utf8_lowercase_folder_core] ERROR");
        end
        $finish;
    end

endmodule

### utf8_lowercase_folder_core.f
+incdir+design
design/u8lf_pkg.sv
design/u8lf_intf.sv
design/utf8_lowercase_folder_core.sv
design/u8lf_checker.sv
tb/u8lf_fold_sb_pkg.sv
tb/tb_top.sv
